// ===== hw/rtl/tlbpt_pkg.sv =====
`default_nettype none

package tlbpt_pkg;

    localparam int TLB_ENTRIES_DEF = 32;
    localparam int SLOT_W          = 5;
    localparam int VA_W            = 64;
    localparam int PA_W            = 32;
    localparam int ASID_W          = 8;
    localparam int MASK_W          = 12;
    localparam int PFN_W           = 20;
    localparam int VPN_W           = 27;
    localparam int S_DATA_W        = 200;
    localparam int M_DATA_W        = 48;
    localparam int APB_ADDR_W      = 3;
    localparam int APB_DATA_W      = 32;

    localparam logic       CMD_WRITE     = 1'b0;
    localparam logic       CMD_TRANSLATE = 1'b1;

    localparam logic       REG_ASID      = 1'b0;

    localparam logic [1:0] FAULT_NONE    = 2'd0;
    localparam logic [1:0] FAULT_MISS    = 2'd1;
    localparam logic [1:0] FAULT_INVALID = 2'd2;
    localparam logic [1:0] FAULT_MOD     = 2'd3;

    typedef struct packed {
        logic [1:0]        region;
        logic [VPN_W-1:0]  vpn;
        logic [ASID_W-1:0] asid;
        logic [MASK_W-1:0] mask;
        logic              glob;
        logic [PFN_W-1:0]  pfn_even;
        logic              dirty_even;
        logic              valid_even;
        logic [PFN_W-1:0]  pfn_odd;
        logic              dirty_odd;
        logic              valid_odd;
    } t_tlb_entry;

    // packed so that translated sits in bit 0
    typedef struct packed {
        logic [SLOT_W-1:0] found_slot;
        logic              entry_found;
        logic [1:0]        fault_code;
        logic [PA_W-1:0]   physical_address;
        logic              translated;
    } t_result;

    typedef struct packed {
        logic accept;
        logic wr_entry;
        logic scanning;
        logic cap_write;
        logic cap_hit;
        logic cap_miss;
        logic load_out;
    } t_dp_cmd;

    typedef struct packed {
        logic hit;
    } t_dp_status;

endpackage

`default_nettype wire

// ===== hw/rtl/tlb_probe_translate.sv =====
`default_nettype none

// Joint TLB with TLB_ENTRIES fully associative entries, each mapping an even/odd
// page pair. A write word (tuser 0) loads one entry, and its result word, all
// zero, passes through the done state into the output register. A translate
// word (tuser 1) scans the entry store one entry per cycle through its
// registered read port and stops at the lowest matching entry; its result then
// passes through the done state into the output register. One word is in work
// at a time; the next is accepted as soon as the previous result has moved into
// the output register, even while that result waits to be taken. The store
// reads as all zero after reset through per-entry valid bits, so no clearing
// pass is run. current_asid sits at APB byte address 0 and resets to 0.

module tlb_probe_translate
    import tlbpt_pkg::*;
#(
    parameter int TLB_ENTRIES = TLB_ENTRIES_DEF
) (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  wire                     i_s_tvalid,
    output logic                    o_s_tready,
    // slot[4:0], virtual_address[68:5], is_store[69], entry_high[133:70],
    // page_mask[145:134], global_flag[146], entry_low_even[172:147],
    // entry_low_odd[198:173], zero pad[199]
    input  wire  [S_DATA_W-1:0]     i_s_tdata,
    // command[0]
    input  wire                     i_s_tuser,
    output logic                    o_m_tvalid,
    input  wire                     i_m_tready,
    // translated[0], physical_address[32:1], fault_code[34:33],
    // entry_found[35], found_slot[40:36], zero pad[47:41]
    output logic [M_DATA_W-1:0]     o_m_tdata,
    input  wire                     psel,
    input  wire                     penable,
    input  wire                     pwrite,
    input  wire  [APB_ADDR_W-1:0]   paddr,
    input  wire  [APB_DATA_W-1:0]   pwdata,
    output logic [APB_DATA_W-1:0]   prdata,
    output logic                    pready
);

    localparam int IW = $clog2(TLB_ENTRIES);

    logic [ASID_W-1:0] r_asid;
    t_dp_cmd           dp_cmd;
    t_dp_status        dp_status;
    t_result           result;
    logic [IW-1:0]     scan_idx;
    logic              cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_asid <= '0;
        end else if (cfg_wr && (paddr[2] == REG_ASID)) begin
            r_asid <= pwdata[ASID_W-1:0];
        end
    end

    assign prdata = (paddr[2] == REG_ASID) ? {{(APB_DATA_W-ASID_W){1'b0}}, r_asid} : '0;

    tlbpt_ctrl #(
        .TLB_ENTRIES (TLB_ENTRIES)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .i_command  (i_s_tuser),
        .i_m_tready (i_m_tready),
        .i_status   (dp_status),
        .o_s_tready (o_s_tready),
        .o_m_tvalid (o_m_tvalid),
        .o_cmd      (dp_cmd),
        .o_idx      (scan_idx)
    );

    tlbpt_datapath #(
        .TLB_ENTRIES (TLB_ENTRIES)
    ) u_datapath (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (dp_cmd),
        .i_idx             (scan_idx),
        .i_asid            (r_asid),
        .i_entry_slot      (i_s_tdata[4:0]),
        .i_virtual_address (i_s_tdata[68:5]),
        .i_is_store        (i_s_tdata[69]),
        .i_entry_high      (i_s_tdata[133:70]),
        .i_page_mask       (i_s_tdata[145:134]),
        .i_global_flag     (i_s_tdata[146]),
        .i_entry_low_even  (i_s_tdata[172:147]),
        .i_entry_low_odd   (i_s_tdata[198:173]),
        .o_status          (dp_status),
        .o_result          (result)
    );

    assign o_m_tdata = {{(M_DATA_W-$bits(t_result)){1'b0}}, result};

    // not ready again in the cycle after an accepted word
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> !o_s_tready)
        else $error("input taken on the cycle after an accept");

    a_translated_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tdata[0]) |->
            (o_m_tdata[34:33] == FAULT_NONE) && o_m_tdata[35])
        else $error("translated result carries a fault or no entry");

    a_miss_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && (o_m_tdata[34:33] == FAULT_MISS)) |->
            (o_m_tdata[40:35] == '0) && (o_m_tdata[32:0] == '0))
        else $error("miss result with entry or address set");

    a_fault_no_address: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && ((o_m_tdata[34:33] == FAULT_INVALID) ||
                        (o_m_tdata[34:33] == FAULT_MOD))) |->
            o_m_tdata[35] && (o_m_tdata[32:0] == '0))
        else $error("fault result with address or without entry");

endmodule

`default_nettype wire

// ===== hw/rtl/tlbpt_datapath.sv =====
`default_nettype none

module tlbpt_datapath
    import tlbpt_pkg::*;
#(
    parameter int TLB_ENTRIES = TLB_ENTRIES_DEF,
    localparam int IW = $clog2(TLB_ENTRIES)
) (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  t_dp_cmd                i_cmd,
    input  wire  [IW-1:0]          i_idx,
    input  wire  [ASID_W-1:0]      i_asid,
    input  wire  [SLOT_W-1:0]      i_entry_slot,
    input  wire  [VA_W-1:0]        i_virtual_address,
    input  wire                    i_is_store,
    input  wire  [VA_W-1:0]        i_entry_high,
    input  wire  [MASK_W-1:0]      i_page_mask,
    input  wire                    i_global_flag,
    input  wire  [25:0]            i_entry_low_even,
    input  wire  [25:0]            i_entry_low_odd,
    output t_dp_status             o_status,
    output t_result                o_result
);

    t_tlb_entry r_mem [TLB_ENTRIES];
    logic [TLB_ENTRIES-1:0] r_valid;

    t_tlb_entry r_rd;
    logic       r_rd_v;
    logic [VA_W-1:0] r_va;
    logic       r_store;
    t_result    r_res;
    t_result    r_out;

    logic [IW+SLOT_W-1:0] slot_ext;
    logic [IW+SLOT_W-1:0] idx_ext;
    logic [IW-1:0]        wr_addr;
    logic [IW-1:0]        rd_addr;
    logic                 slot_ok;
    t_tlb_entry           wr_ent;
    t_tlb_entry           ent;
    logic [VPN_W-1:0]     keep;
    logic                 vpn_ok;
    logic                 asid_ok;
    logic [MASK_W:0]      mask_p1;
    logic                 odd;
    logic [PFN_W-1:0]     pfn;
    logic                 lo_dirty;
    logic                 lo_valid;
    t_result              hit_res;

    assign slot_ext = {{IW{1'b0}}, i_entry_slot};
    assign wr_addr  = slot_ext[IW-1:0];
    assign slot_ok  = 32'(i_entry_slot) < 32'(TLB_ENTRIES);
    assign idx_ext  = {{SLOT_W{1'b0}}, i_idx};
    assign rd_addr  = i_cmd.scanning ? IW'(i_idx + 1'b1) : '0;

    always_comb begin
        wr_ent            = '0;
        wr_ent.region     = i_entry_high[63:62];
        wr_ent.vpn        = i_entry_high[39:13];
        wr_ent.asid       = i_entry_high[7:0];
        wr_ent.mask       = i_page_mask;
        wr_ent.glob       = i_global_flag;
        wr_ent.pfn_even   = i_entry_low_even[25:6];
        wr_ent.dirty_even = i_entry_low_even[2];
        wr_ent.valid_even = i_entry_low_even[1];
        wr_ent.pfn_odd    = i_entry_low_odd[25:6];
        wr_ent.dirty_odd  = i_entry_low_odd[2];
        wr_ent.valid_odd  = i_entry_low_odd[1];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_entry && slot_ok) begin
            r_mem[wr_addr] <= wr_ent;
        end
        r_rd <= r_mem[rd_addr];
    end

    // entries never written read as the all-zero reset entry
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_rd_v  <= 1'b0;
        end else begin
            if (i_cmd.wr_entry && slot_ok) begin
                r_valid[wr_addr] <= 1'b1;
            end
            r_rd_v <= r_valid[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_va    <= i_virtual_address;
            r_store <= i_is_store;
        end
    end

    always_comb begin
        ent      = r_rd_v ? r_rd : '0;
        keep     = {{(VPN_W-MASK_W){1'b1}}, ~ent.mask};
        vpn_ok   = (ent.region == r_va[63:62]) &&
                   (((ent.vpn ^ r_va[39:13]) & keep) == '0);
        asid_ok  = ent.glob || (ent.asid == i_asid);
        mask_p1  = {1'b0, ent.mask} + 13'd1;
        odd      = |(r_va[24:12] & mask_p1);
        pfn      = odd ? ent.pfn_odd   : ent.pfn_even;
        lo_dirty = odd ? ent.dirty_odd : ent.dirty_even;
        lo_valid = odd ? ent.valid_odd : ent.valid_even;

        hit_res             = '0;
        hit_res.entry_found = 1'b1;
        hit_res.found_slot  = idx_ext[SLOT_W-1:0];
        if (!lo_valid) begin
            hit_res.fault_code = FAULT_INVALID;
        end else if (r_store && !lo_dirty) begin
            hit_res.fault_code = FAULT_MOD;
        end else begin
            hit_res.fault_code       = FAULT_NONE;
            hit_res.translated       = 1'b1;
            hit_res.physical_address = {pfn, 12'h000} |
                                       (r_va[31:0] & {8'h00, ent.mask, 12'hFFF});
        end
    end

    assign o_status.hit = vpn_ok && asid_ok;

    always_ff @(posedge i_clk) begin
        if (i_cmd.cap_write) begin
            r_res <= '0;
        end else if (i_cmd.cap_hit) begin
            r_res <= hit_res;
        end else if (i_cmd.cap_miss) begin
            r_res            <= '0;
            r_res.fault_code <= FAULT_MISS;
        end
        if (i_cmd.load_out) begin
            r_out <= r_res;
        end
    end

    assign o_result = r_out;

endmodule

`default_nettype wire

// ===== hw/rtl/tlbpt_ctrl.sv =====
`default_nettype none

module tlbpt_ctrl
    import tlbpt_pkg::*;
#(
    parameter int TLB_ENTRIES = TLB_ENTRIES_DEF,
    localparam int IW = $clog2(TLB_ENTRIES)
) (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_s_tvalid,
    input  wire              i_command,
    input  wire              i_m_tready,
    input  t_dp_status       i_status,
    output logic             o_s_tready,
    output logic             o_m_tvalid,
    output t_dp_cmd          o_cmd,
    output logic [IW-1:0]    o_idx
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    localparam logic [IW-1:0] LAST_IDX = IW'(TLB_ENTRIES - 1);

    logic [1:0]    r_state,     n_state;
    logic [IW-1:0] r_idx,       n_idx;
    logic          r_out_valid, n_out_valid;
    logic          accept;

    assign accept = i_s_tvalid && (r_state == ST_IDLE);

    always_comb begin
        n_state     = r_state;
        n_idx       = r_idx;
        n_out_valid = r_out_valid;
        o_cmd          = '0;
        o_cmd.accept   = accept;
        o_cmd.scanning = (r_state == ST_SCAN);

        if (r_out_valid && i_m_tready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    if (i_command == CMD_WRITE) begin
                        o_cmd.wr_entry  = 1'b1;
                        o_cmd.cap_write = 1'b1;
                        n_state         = ST_DONE;
                    end else begin
                        n_idx   = '0;
                        n_state = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                // lowest matching entry wins: stop at the first hit
                if (i_status.hit) begin
                    o_cmd.cap_hit = 1'b1;
                    n_state       = ST_DONE;
                end else if (r_idx == LAST_IDX) begin
                    o_cmd.cap_miss = 1'b1;
                    n_state        = ST_DONE;
                end else begin
                    n_idx = IW'(r_idx + 1'b1);
                end
            end
            ST_DONE: begin
                if (!r_out_valid || i_m_tready) begin
                    o_cmd.load_out = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_idx       <= n_idx;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_s_tready = (r_state == ST_IDLE);
    assign o_m_tvalid = r_out_valid;
    assign o_idx      = r_idx;

endmodule

`default_nettype wire
